### rtl/core/ccod_pkg.sv
// ----------------------------------------------------------------------------
// ccod_pkg
// Shared types and constants for the CC orientation detector with debounce.
// ----------------------------------------------------------------------------
package ccod_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_INITIAL      = 2'd0;
  localparam mode_t MODE_DISCONNECTED = 2'd1;
  localparam mode_t MODE_NORMAL       = 2'd2;
  localparam mode_t MODE_FLIPPED      = 2'd3;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned THR_W   = 15;
  localparam int unsigned DBN_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CC_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VBUS_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE       = 2'd2;

  localparam logic [THR_W-1:0] CC_THRESHOLD_RST   = 15'd0;
  localparam logic [THR_W-1:0] VBUS_THRESHOLD_RST = 15'd2000;
  localparam logic [DBN_W-1:0] DEBOUNCE_RST       = 4'd5;

  typedef struct packed {
    logic  rejected;
    mode_t mode;
  } class_t;

  typedef struct packed {
    logic  mux_enable_l;
    logic  mux_select;
    logic  hub_reset_l;
    mode_t applied_state;
    logic  state_changed;
    logic  sample_rejected;
  } result_t;

endpackage

### rtl/core/ccod_classify.sv
// ----------------------------------------------------------------------------
// ccod_classify
// Classifies one CC/VBUS sample and flags read errors.
// ----------------------------------------------------------------------------
module ccod_classify (
  input  logic signed [ccod_pkg::LEVEL_W-1:0] cc1_level_mv,
  input  logic signed [ccod_pkg::LEVEL_W-1:0] cc2_level_mv,
  input  logic signed [ccod_pkg::LEVEL_W-1:0] vbus_level_mv,
  input  logic        [ccod_pkg::THR_W-1:0]   cc_threshold_mv,
  input  logic        [ccod_pkg::THR_W-1:0]   vbus_threshold_mv,
  output ccod_pkg::class_t                    cls
);
  import ccod_pkg::*;

  logic signed [LEVEL_W-1:0] cc_thr_s;
  logic signed [LEVEL_W-1:0] vbus_thr_s;
  logic                      cc1_act;
  logic                      cc2_act;
  logic                      vbus_ok;

  assign cc_thr_s   = $signed({1'b0, cc_threshold_mv});
  assign vbus_thr_s = $signed({1'b0, vbus_threshold_mv});
  assign cc1_act    = cc1_level_mv > cc_thr_s;
  assign cc2_act    = cc2_level_mv > cc_thr_s;
  assign vbus_ok    = vbus_level_mv > vbus_thr_s;

  always_comb begin
    cls.rejected = cc1_level_mv[LEVEL_W-1] | cc2_level_mv[LEVEL_W-1];
    if (!vbus_ok) begin
      cls.mode = MODE_DISCONNECTED;
    end else if (cc1_act && !cc2_act) begin
      cls.mode = MODE_NORMAL;
    end else if (!cc1_act && cc2_act) begin
      cls.mode = MODE_FLIPPED;
    end else begin
      cls.mode = MODE_DISCONNECTED;
    end
  end

endmodule

### rtl/core/ccod_debounce.sv
// ----------------------------------------------------------------------------
// ccod_debounce
// Debounce counter, applied mode and select latch; forms the result fields.
// ----------------------------------------------------------------------------
module ccod_debounce (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  ccod_pkg::class_t                cls,
  input  logic [ccod_pkg::DBN_W-1:0]      debounce_samples,
  output ccod_pkg::result_t               res
);
  import ccod_pkg::*;

  mode_t            cur_mode_r, cur_mode_nxt;
  mode_t            cand_mode_r, cand_mode_nxt;
  logic [DBN_W-1:0] match_cnt_r, match_cnt_nxt;
  logic             sel_r, sel_nxt;
  logic [DBN_W-1:0] need;
  logic [DBN_W:0]   cnt;
  logic             changed;

  assign need = (debounce_samples == '0) ? DBN_W'(1) : debounce_samples;

  always_comb begin
    cur_mode_nxt  = cur_mode_r;
    cand_mode_nxt = cand_mode_r;
    match_cnt_nxt = match_cnt_r;
    sel_nxt       = sel_r;
    changed       = 1'b0;
    cnt           = {1'b0, match_cnt_r} + (DBN_W+1)'(1);
    if (!cls.rejected) begin
      if (cls.mode != cand_mode_r) begin
        cand_mode_nxt = cls.mode;
        cnt           = (DBN_W+1)'(1);
      end
      match_cnt_nxt = cnt[DBN_W-1:0];
      if (cnt >= {1'b0, need}) begin
        match_cnt_nxt = need;
        if (cand_mode_nxt != cur_mode_r) begin
          cur_mode_nxt = cand_mode_nxt;
          changed      = 1'b1;
          if (cand_mode_nxt == MODE_NORMAL) begin
            sel_nxt = 1'b0;
          end else if (cand_mode_nxt == MODE_FLIPPED) begin
            sel_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    res.mux_enable_l    = (cur_mode_nxt == MODE_NORMAL) || (cur_mode_nxt == MODE_FLIPPED);
    res.mux_select      = sel_nxt;
    res.hub_reset_l     = (cur_mode_nxt == MODE_DISCONNECTED);
    res.applied_state   = cur_mode_nxt;
    res.state_changed   = changed;
    res.sample_rejected = cls.rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mode_r  <= MODE_INITIAL;
      cand_mode_r <= MODE_INITIAL;
      match_cnt_r <= '0;
      sel_r       <= 1'b0;
    end else if (adv) begin
      cur_mode_r  <= cur_mode_nxt;
      cand_mode_r <= cand_mode_nxt;
      match_cnt_r <= match_cnt_nxt;
      sel_r       <= sel_nxt;
    end
  end

  a_count_set: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !cls.rejected |=> match_cnt_r != '0)
    else $error("match count zero after accepted sample");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    adv && cls.rejected |=> $stable(cur_mode_r) && $stable(cand_mode_r) && $stable(sel_r))
    else $error("state moved on rejected sample");

  a_no_return_initial: assert property (@(posedge clk) disable iff (!rst_n)
    cur_mode_r != MODE_INITIAL |=> cur_mode_r != MODE_INITIAL)
    else $error("applied mode returned to initial");

endmodule

### rtl/core/cc_orientation_debounce_mux_top.sv
// ----------------------------------------------------------------------------
// cc_orientation_debounce_mux_top
// USB Type-C CC orientation detector with debounce driving a host mux.
// ----------------------------------------------------------------------------
// Path: an accepted request is captured in the stage-1 registers; its result
//   is registered in the output register when stage 1 advances.
// Throughput: 1 request per cycle while out_stall is low; classify and
//   debounce update fit one stage. Reset: synchronous active-low rst_n
//   clears both stages, the applied and candidate modes, the match count
//   and the select latch; the config registers take their reset values.
module cc_orientation_debounce_mux_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [ccod_pkg::LEVEL_W-1:0]     in_cc1_level_mv,
  input  logic signed [ccod_pkg::LEVEL_W-1:0]     in_cc2_level_mv,
  input  logic signed [ccod_pkg::LEVEL_W-1:0]     in_vbus_level_mv,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_mux_enable_l,
  output logic                                    out_mux_select,
  output logic                                    out_hub_reset_l,
  output logic [1:0]                              out_applied_state,
  output logic                                    out_state_changed,
  output logic                                    out_sample_rejected,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ccod_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ccod_pkg::THR_W-1:0]              cfg_data
);
  import ccod_pkg::*;

  logic [THR_W-1:0]          cc_thr_r;
  logic [THR_W-1:0]          vbus_thr_r;
  logic [DBN_W-1:0]          dbn_r;
  logic                      s1_valid_r;
  logic signed [LEVEL_W-1:0] cc1_r;
  logic signed [LEVEL_W-1:0] cc2_r;
  logic signed [LEVEL_W-1:0] vbus_r;
  logic                      out_valid_r;
  result_t                   out_res_r;
  result_t                   res;
  class_t                    cls;
  logic                      adv;
  logic                      in_acc;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_thr_r   <= CC_THRESHOLD_RST;
      vbus_thr_r <= VBUS_THRESHOLD_RST;
      dbn_r      <= DEBOUNCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CC_THRESHOLD:   cc_thr_r   <= cfg_data;
        REG_VBUS_THRESHOLD: vbus_thr_r <= cfg_data;
        REG_DEBOUNCE:       dbn_r      <= cfg_data[DBN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cc1_r  <= in_cc1_level_mv;
      cc2_r  <= in_cc2_level_mv;
      vbus_r <= in_vbus_level_mv;
    end
  end

  ccod_classify u_classify (
    .cc1_level_mv      (cc1_r),
    .cc2_level_mv      (cc2_r),
    .vbus_level_mv     (vbus_r),
    .cc_threshold_mv   (cc_thr_r),
    .vbus_threshold_mv (vbus_thr_r),
    .cls               (cls)
  );

  ccod_debounce u_debounce (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .cls              (cls),
    .debounce_samples (dbn_r),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mux_enable_l    = out_res_r.mux_enable_l;
  assign out_mux_select      = out_res_r.mux_select;
  assign out_hub_reset_l     = out_res_r.hub_reset_l;
  assign out_applied_state   = out_res_r.applied_state;
  assign out_state_changed   = out_res_r.state_changed;
  assign out_sample_rejected = out_res_r.sample_rejected;

  a_reject_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.sample_rejected && out_res_r.state_changed))
    else $error("rejected request reported a state change");

  a_change_not_initial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.state_changed |-> out_res_r.applied_state != MODE_INITIAL)
    else $error("state change to initial mode");

  a_pins_match_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.mux_enable_l == out_res_r.applied_state[1] &&
                    out_res_r.hub_reset_l ==
                      (out_res_r.applied_state == MODE_DISCONNECTED))
    else $error("pin outputs disagree with applied state");

endmodule
